### rtl/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg
// Shared constants, action codes and control types of the ordered array list.
// ----------------------------------------------------------------------------
package oal_pkg;

   // fixed field widths
   localparam int KEY_W          = 16;
   localparam int PAYLOAD_PORT_W = 32;
   localparam int ACTION_W       = 3;

   // default sizing
   localparam int OAL_CAPACITY     = 16;
   localparam int OAL_PAYLOAD_BITS = 32;

   // transaction action codes
   localparam logic [ACTION_W-1:0] ACT_INS_FRONT   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_INS_BACK    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INS_ORDERED = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REM_FRONT   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_REM_BACK    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_STATUS      = 3'd5;

   // datapath update operations
   localparam logic [1:0] OP_NONE      = 2'd0;
   localparam logic [1:0] OP_INSERT    = 2'd1;
   localparam logic [1:0] OP_POP_FRONT = 2'd2;
   localparam logic [1:0] OP_POP_BACK  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic       load;       // capture entry, compare flags, start position
      logic       pos_back;   // start position at the back instead of the front
      logic       scan_step;  // advance the ordered-insert search
      logic       apply;      // update the list and the result register
      logic [1:0] op;
      logic       ok;
   } oal_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic scan_hit;   // entry at the search position is not below the new key
      logic scan_end;   // search position reached the entry count
   } oal_status_type;

endpackage

### rtl/ordered_array_list_top.sv
// ----------------------------------------------------------------------------
// ordered_array_list_top
// Fixed-capacity list of keyed entries with front, back and sorted insert.
// ----------------------------------------------------------------------------
// The list holds up to CAPACITY entries, each a signed 16-bit key and a
// payload of PAYLOAD_BITS bits, in registers that shift in parallel. One
// request transaction is handled at a time and gives one response
// transaction with the success flag, the count, the empty and full flags and
// the front entry after the action. Insert front, insert back, the removals,
// status and refused actions go from acceptance straight to the update; an
// ordered insert on a list that is not full first runs a linear search for
// its position that checks one stored entry per cycle. The response sits
// in an output register, so the next request is taken while the previous
// response still waits; the update stalls only if that register is still
// full. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ordered_array_list_top
   import oal_pkg::*;
#(
   parameter int CAPACITY     = OAL_CAPACITY,
   parameter int PAYLOAD_BITS = OAL_PAYLOAD_BITS
)
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ACTION_W-1:0]               req_action,
   input  logic signed [KEY_W-1:0]           req_entry_key,
   input  logic [PAYLOAD_PORT_W-1:0]         req_entry_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic [$clog2(CAPACITY + 1)-1:0]   rsp_count,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic signed [KEY_W-1:0]           rsp_front_key,
   output logic [PAYLOAD_PORT_W-1:0]         rsp_front_payload
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   oal_cmd_type    cmd;
   oal_status_type status;

   // sequencer
   oal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   // entry storage and result register
   oal_datapath #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CNT_W        (CNT_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_entry_key     (req_entry_key),
      .req_entry_payload (req_entry_payload),
      .cmd               (cmd),
      .status            (status),
      .rsp_ok            (rsp_ok),
      .rsp_count         (rsp_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_front_key     (rsp_front_key),
      .rsp_front_payload (rsp_front_payload)
   );

endmodule

### rtl/oal_ctrl.sv
// ----------------------------------------------------------------------------
// oal_ctrl
// Sequencer of the ordered array list: takes one transaction at a time, runs
// the ordered-insert search and issues the list update and the result.
// ----------------------------------------------------------------------------
module oal_ctrl
   import oal_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACTION_W-1:0] req_action,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output oal_cmd_type         cmd,
   input  oal_status_type      status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load     = 1'b1;
               cmd.pos_back = (req_action == ACT_INS_BACK);
               action_in    = req_action;
               if (req_action == ACT_INS_ORDERED && !status.full) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_end || status.scan_hit) begin
               state_in = ST_APPLY;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_APPLY: begin
            unique case (action_ff) inside
               ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_ORDERED: begin
                  if (!status.full) begin
                     cmd.op = OP_INSERT;
                     cmd.ok = 1'b1;
                  end
               end
               ACT_REM_FRONT: begin
                  if (!status.empty) begin
                     cmd.op = OP_POP_FRONT;
                     cmd.ok = 1'b1;
                  end
               end
               ACT_REM_BACK: begin
                  if (!status.empty) begin
                     cmd.op = OP_POP_BACK;
                     cmd.ok = 1'b1;
                  end
               end
               ACT_STATUS: begin
                  cmd.ok = 1'b1;
               end
               default: begin
                  cmd.op = OP_NONE;
               end
            endcase
            if (out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
   end

`ifndef NO_ASSERTIONS
   // one transaction in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new transaction taken while one is in flight");

   // every update produces a pending result
   a_apply_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> rsp_valid)
      else $error("list update without a result");

   // the search runs only for an ordered insert
   a_scan_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (action_ff == ACT_INS_ORDERED))
      else $error("search running for a non-ordered action");
`endif

endmodule

### rtl/oal_datapath.sv
// ----------------------------------------------------------------------------
// oal_datapath
// Entry cells with parallel shift, entry count, ordered-insert search
// position and the result register.
// ----------------------------------------------------------------------------
module oal_datapath
   import oal_pkg::*;
#(
   parameter int CAPACITY     = OAL_CAPACITY,
   parameter int PAYLOAD_BITS = OAL_PAYLOAD_BITS,
   parameter int CNT_W        = $clog2(CAPACITY + 1)
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [KEY_W-1:0]   req_entry_key,
   input  logic [PAYLOAD_PORT_W-1:0] req_entry_payload,
   input  oal_cmd_type               cmd,
   output oal_status_type            status,
   output logic                      rsp_ok,
   output logic [CNT_W-1:0]          rsp_count,
   output logic                      rsp_is_empty,
   output logic                      rsp_is_full,
   output logic signed [KEY_W-1:0]   rsp_front_key,
   output logic [PAYLOAD_PORT_W-1:0] rsp_front_payload
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic signed [KEY_W-1:0]   key_ff [CAPACITY];
   logic signed [KEY_W-1:0]   key_in [CAPACITY];
   logic [PAYLOAD_BITS-1:0]   pay_ff [CAPACITY];
   logic [PAYLOAD_BITS-1:0]   pay_in [CAPACITY];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          pos_ff, pos_in;
   logic [CAPACITY-1:0]       flags_ff, flags_in;
   logic signed [KEY_W-1:0]   new_key_ff, new_key_in;
   logic [PAYLOAD_BITS-1:0]   new_pay_ff, new_pay_in;
   logic                      rsp_ok_ff;
   logic [CNT_W-1:0]          rsp_count_ff;
   logic signed [KEY_W-1:0]   rsp_key_ff;
   logic [PAYLOAD_PORT_W-1:0] rsp_pay_ff;

   // status toward the controller
   assign status.full     = (count_ff == CAP_CNT);
   assign status.empty    = (count_ff == '0);
   assign status.scan_hit = flags_ff[0];
   assign status.scan_end = (pos_ff == count_ff);

   // capture of the candidate entry
   always_comb begin
      new_key_in = new_key_ff;
      new_pay_in = new_pay_ff;
      if (cmd.load) begin
         new_key_in = req_entry_key;
         new_pay_in = PAYLOAD_BITS'(req_entry_payload);
      end
   end

   // per-entry compare flags, shifted toward position zero during the search
   always_comb begin
      flags_in = flags_ff;
      if (cmd.load) begin
         for (int i = 0; i < CAPACITY; i++) begin
            flags_in[i] = (key_ff[i] >= req_entry_key);
         end
      end else if (cmd.scan_step) begin
         flags_in = flags_ff >> 1;
      end
   end

   // insert position
   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) begin
         pos_in = cmd.pos_back ? count_ff : '0;
      end else if (cmd.scan_step) begin
         pos_in = pos_ff + CNT_W'(1);
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.apply) begin
         case (cmd.op) inside
            OP_INSERT:                 count_in = count_ff + CNT_W'(1);
            OP_POP_FRONT, OP_POP_BACK: count_in = count_ff - CNT_W'(1);
            default:                   count_in = count_ff;
         endcase
      end
   end

   // entry cells: each takes its own value, a neighbor's, or the new entry
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int               PREV = (i > 0) ? i - 1 : 0;
      localparam int               NEXT = (i < CAPACITY - 1) ? i + 1 : i;
      localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);

      always_comb begin
         key_in[i] = key_ff[i];
         pay_in[i] = pay_ff[i];
         if (cmd.apply) begin
            case (cmd.op)
               OP_INSERT: begin
                  if (IDX == pos_ff) begin
                     key_in[i] = new_key_ff;
                     pay_in[i] = new_pay_ff;
                  end else if (IDX > pos_ff) begin
                     key_in[i] = key_ff[PREV];
                     pay_in[i] = pay_ff[PREV];
                  end
               end
               OP_POP_FRONT: begin
                  key_in[i] = key_ff[NEXT];
                  pay_in[i] = pay_ff[NEXT];
               end
               default: begin
                  key_in[i] = key_ff[i];
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         key_ff[i] <= key_in[i];
         pay_ff[i] <= pay_in[i];
      end
   end

   // control state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff     <= pos_in;
      flags_ff   <= flags_in;
      new_key_ff <= new_key_in;
      new_pay_ff <= new_pay_in;
   end

   // result register, loaded from the updated list
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_ok_ff    <= cmd.ok;
         rsp_count_ff <= count_in;
         if (count_in == '0) begin
            rsp_key_ff <= '0;
            rsp_pay_ff <= '0;
         end else begin
            rsp_key_ff <= key_in[0];
            rsp_pay_ff <= PAYLOAD_PORT_W'(pay_in[0]);
         end
      end
   end

   assign rsp_ok            = rsp_ok_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_is_empty      = (rsp_count_ff == '0);
   assign rsp_is_full       = (rsp_count_ff == CAP_CNT);
   assign rsp_front_key     = rsp_key_ff;
   assign rsp_front_payload = rsp_pay_ff;

`ifndef NO_ASSERTIONS
   // count never exceeds the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   // the search only advances over stored entries
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (pos_ff < count_ff))
      else $error("search advanced past the last entry");

   // a removal is issued only on a non-empty list
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && (cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK))
         |-> (count_ff != '0))
      else $error("removal from an empty list");
`endif

endmodule
